>>> sv/wfrm_pkg.sv
// Package for the windowed frame rate meter: sizes, register codes and the control program.
package wfrm_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = 32 + PTR_W;
    localparam int DCNT_W     = $clog2(SUM_W + 1);

    localparam int TS_W       = 32;
    localparam int AVG_W      = 32;
    localparam int FPS_W      = 24;
    localparam int WIN_W      = 10;
    localparam int SHOW_W     = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_W      = 120;

    localparam logic [WIN_W-1:0]  WIN_MAX_REG = WIN_W'(1000);
    localparam logic [WIN_W-1:0]  WIN_RESET   = WIN_W'(60);
    localparam logic [SHOW_W-1:0] SHOW_MIN_MS = SHOW_W'(16);
    localparam logic [SHOW_W-1:0] SHOW_MAX_MS = SHOW_W'(5000);
    localparam logic [SHOW_W-1:0] SHOW_RESET  = SHOW_W'(80);
    localparam logic [FPS_W-1:0]  FPS_NUM     = FPS_W'(16000000);
    localparam logic [9:0]        US_PER_MS   = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MS = CFG_IDX_W'(1);

    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_FIRST,
        OP_STORE,
        OP_READ,
        OP_DRAIN,
        OP_DIV_SUM,
        OP_DIV_STEP,
        OP_SET_AVG,
        OP_SET_FPS,
        OP_SHOW,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_BEAT,
        C_FIRST_FRAME,
        C_READ_MORE,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam step_t STEP_IDLE = 4'd0;
    localparam step_t STEP_READ = 4'd3;
    localparam step_t STEP_DIV1 = 4'd6;
    localparam step_t STEP_DIV2 = 4'd8;
    localparam step_t STEP_EMIT = 4'd11;

    // Control store: a jump is taken when its condition holds, else the next step follows.
    function automatic ctrl_word_t program_word(input step_t step);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
        unique case (step)
            4'd0:    w = '{op: OP_ACCEPT,   cond: C_NO_BEAT,     target: STEP_IDLE};
            4'd1:    w = '{op: OP_FIRST,    cond: C_FIRST_FRAME, target: STEP_EMIT};
            4'd2:    w = '{op: OP_STORE,    cond: C_NEVER,       target: STEP_IDLE};
            4'd3:    w = '{op: OP_READ,     cond: C_READ_MORE,   target: STEP_READ};
            4'd4:    w = '{op: OP_DRAIN,    cond: C_NEVER,       target: STEP_IDLE};
            4'd5:    w = '{op: OP_DIV_SUM,  cond: C_NEVER,       target: STEP_IDLE};
            4'd6:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: STEP_DIV1};
            4'd7:    w = '{op: OP_SET_AVG,  cond: C_NEVER,       target: STEP_IDLE};
            4'd8:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: STEP_DIV2};
            4'd9:    w = '{op: OP_SET_FPS,  cond: C_NEVER,       target: STEP_IDLE};
            4'd10:   w = '{op: OP_SHOW,     cond: C_NEVER,       target: STEP_IDLE};
            4'd11:   w = '{op: OP_EMIT,     cond: C_OUT_BUSY,    target: STEP_EMIT};
            default: w = '{op: OP_NOP,      cond: C_ALWAYS,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> sv/windowed_frame_rate_meter_unit.sv
// Windowed frame rate meter: microcoded sequencer, interval ring and shared serial divider.
//
// Each input beat on the s_ channel is one frame marker carrying a 32-bit microsecond
// timestamp. Each accepted beat yields exactly one output beat on the m_ channel with
// the measured flag, the windowed mean frame time, fps times 16 and the display copies.
// The first marker after reset only records the time and reports the current state.
// Processing is sequenced by a small control store. For each marker the ring memory is
// read one entry per cycle over the F intervals in the window (F from 1 to 1000), and
// one shared restoring divider computes first the mean and then fps.
// s_tready is high only while the sequencer waits for a marker. The result sits in an
// output register; the next marker can be taken while it waits, and the sequencer only
// stalls at its final step if the receiver still holds the previous result.
// Reset clears all control and measurement state and loads window_len 60 and
// display_interval_ms 80. The ring memory needs no clearing pass: only entries written
// since reset are read. Configuration may be written only while the block is idle.
module windowed_frame_rate_meter_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wfrm_pkg::TS_W-1:0]           s_tdata,   // timestamp_us
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // measured, avg_frame_us, fps_x16, shown_frame_us, shown_fps_x16, zero fill
    output logic [wfrm_pkg::OUT_W-1:0]          m_tdata,
    input  logic                                cfg_we,
    input  logic [wfrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wfrm_pkg::CFG_W-1:0]          cfg_data
);

    logic [wfrm_pkg::AVG_W-1:0]  ring [wfrm_pkg::MAX_WINDOW];

    wfrm_pkg::step_t             pc_reg, pc_next;
    wfrm_pkg::ctrl_word_t        cw;
    logic                        cond_hit;

    logic [wfrm_pkg::WIN_W-1:0]  win_reg;
    logic [wfrm_pkg::SHOW_W-1:0] show_ms_reg;
    logic [wfrm_pkg::TS_W-1:0]   now_reg;
    logic [wfrm_pkg::TS_W-1:0]   prev_frame_reg;
    logic [wfrm_pkg::TS_W-1:0]   prev_show_reg;
    logic                        seen_frame_reg;
    logic                        seen_show_reg;
    logic [wfrm_pkg::PTR_W-1:0]  slot_reg;
    logic [wfrm_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [wfrm_pkg::FILL_W-1:0] fill_reg;
    logic [wfrm_pkg::FILL_W-1:0] rd_cnt_reg;
    logic                        pend_reg;
    logic [wfrm_pkg::AVG_W-1:0]  rd_q_reg;
    logic [wfrm_pkg::SUM_W-1:0]  sum_reg;
    logic [wfrm_pkg::AVG_W-1:0]  cur_avg_reg;
    logic [wfrm_pkg::FPS_W-1:0]  cur_fps_reg;
    logic [wfrm_pkg::AVG_W-1:0]  held_avg_reg;
    logic [wfrm_pkg::FPS_W-1:0]  held_fps_reg;
    logic                        m_tvalid_reg;
    logic [wfrm_pkg::OUT_W-1:0]  m_tdata_reg;

    logic [wfrm_pkg::SUM_W-1:0]  dvd_reg;
    logic [wfrm_pkg::AVG_W-1:0]  dvsr_reg;
    logic [wfrm_pkg::AVG_W-1:0]  rem_reg;
    logic [wfrm_pkg::DCNT_W-1:0] dcnt_reg;
    logic [wfrm_pkg::AVG_W:0]    rem_sh;
    logic [wfrm_pkg::AVG_W:0]    rem_diff;
    logic                        rem_ge;

    logic [wfrm_pkg::WIN_W-1:0]  cfg_win;
    logic [wfrm_pkg::SHOW_W-1:0] cfg_show;
    logic [wfrm_pkg::FILL_W-1:0] cfg_act;
    logic [wfrm_pkg::FILL_W-1:0] act_win;
    logic [wfrm_pkg::FILL_W-1:0] fill_inc;
    logic [wfrm_pkg::TS_W-1:0]   delta;
    logic [wfrm_pkg::TS_W-1:0]   elapsed;
    logic [22:0]                 show_thr;
    logic                        out_busy;
    logic                        beat_in;

    assign cw       = wfrm_pkg::program_word(pc_reg);
    assign beat_in  = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign s_tready = (pc_reg == wfrm_pkg::STEP_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign delta    = now_reg - prev_frame_reg;
    assign elapsed  = now_reg - prev_show_reg;
    assign show_thr = 23'(show_ms_reg * wfrm_pkg::US_PER_MS);
    assign fill_inc = fill_reg + 1'b1;

    assign rem_sh   = {rem_reg, dvd_reg[wfrm_pkg::SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};
    assign rem_ge   = (rem_sh >= {1'b0, dvsr_reg});

    always_comb
    begin
        if (wfrm_pkg::FILL_W'(win_reg) > wfrm_pkg::FILL_W'(wfrm_pkg::MAX_WINDOW))
            act_win = wfrm_pkg::FILL_W'(wfrm_pkg::MAX_WINDOW);
        else
            act_win = wfrm_pkg::FILL_W'(win_reg);

        cfg_win = cfg_data[wfrm_pkg::WIN_W-1:0];
        if (cfg_win == '0)
            cfg_win = wfrm_pkg::WIN_W'(1);
        else if (cfg_win > wfrm_pkg::WIN_MAX_REG)
            cfg_win = wfrm_pkg::WIN_MAX_REG;
        if (wfrm_pkg::FILL_W'(cfg_win) > wfrm_pkg::FILL_W'(wfrm_pkg::MAX_WINDOW))
            cfg_act = wfrm_pkg::FILL_W'(wfrm_pkg::MAX_WINDOW);
        else
            cfg_act = wfrm_pkg::FILL_W'(cfg_win);

        cfg_show = cfg_data[wfrm_pkg::SHOW_W-1:0];
        if (cfg_show < wfrm_pkg::SHOW_MIN_MS)
            cfg_show = wfrm_pkg::SHOW_MIN_MS;
        else if (cfg_show > wfrm_pkg::SHOW_MAX_MS)
            cfg_show = wfrm_pkg::SHOW_MAX_MS;
    end

    always_comb
    begin
        unique case (cw.cond)
            wfrm_pkg::C_NEVER:       cond_hit = 1'b0;
            wfrm_pkg::C_ALWAYS:      cond_hit = 1'b1;
            wfrm_pkg::C_NO_BEAT:     cond_hit = !beat_in;
            wfrm_pkg::C_FIRST_FRAME: cond_hit = !seen_frame_reg;
            wfrm_pkg::C_READ_MORE:   cond_hit = (wfrm_pkg::FILL_W'(rd_cnt_reg + 1'b1) < fill_reg);
            wfrm_pkg::C_DIV_MORE:    cond_hit = (dcnt_reg != wfrm_pkg::DCNT_W'(1));
            wfrm_pkg::C_OUT_BUSY:    cond_hit = out_busy;
            default:                 cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? cw.target : wfrm_pkg::step_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (cw.op == wfrm_pkg::OP_STORE)
            ring[slot_reg] <= delta;
        if (cw.op == wfrm_pkg::OP_READ)
            rd_q_reg <= ring[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= wfrm_pkg::STEP_IDLE;
            win_reg        <= wfrm_pkg::WIN_RESET;
            show_ms_reg    <= wfrm_pkg::SHOW_RESET;
            now_reg        <= '0;
            prev_frame_reg <= '0;
            prev_show_reg  <= '0;
            seen_frame_reg <= 1'b0;
            seen_show_reg  <= 1'b0;
            slot_reg       <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            sum_reg        <= '0;
            cur_avg_reg    <= '0;
            cur_fps_reg    <= '0;
            held_avg_reg   <= '0;
            held_fps_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            dvd_reg        <= '0;
            dvsr_reg       <= '0;
            rem_reg        <= '0;
            dcnt_reg       <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cw.op == wfrm_pkg::OP_EMIT && !out_busy)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (cfg_we && cfg_index == wfrm_pkg::REG_WINDOW_LEN)
            begin
                win_reg <= cfg_win;
                if (fill_reg > cfg_act)
                    fill_reg <= cfg_act;
            end
            if (cfg_we && cfg_index == wfrm_pkg::REG_DISPLAY_MS)
                show_ms_reg <= cfg_show;

            unique case (cw.op)
                wfrm_pkg::OP_ACCEPT:
                begin
                    if (beat_in)
                        now_reg <= s_tdata;
                end
                wfrm_pkg::OP_FIRST:
                begin
                    if (!seen_frame_reg)
                    begin
                        prev_frame_reg <= now_reg;
                        prev_show_reg  <= now_reg;
                        seen_frame_reg <= 1'b1;
                    end
                end
                wfrm_pkg::OP_STORE:
                begin
                    prev_frame_reg <= now_reg;
                    rd_ptr_reg     <= slot_reg;
                    if (slot_reg == wfrm_pkg::PTR_W'(wfrm_pkg::MAX_WINDOW - 1))
                        slot_reg <= '0;
                    else
                        slot_reg <= slot_reg + 1'b1;
                    fill_reg   <= (fill_inc > act_win) ? act_win : fill_inc;
                    rd_cnt_reg <= '0;
                    sum_reg    <= '0;
                    pend_reg   <= 1'b0;
                end
                wfrm_pkg::OP_READ:
                begin
                    if (pend_reg)
                        sum_reg <= sum_reg + wfrm_pkg::SUM_W'(rd_q_reg);
                    pend_reg   <= 1'b1;
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_ptr_reg == '0)
                        rd_ptr_reg <= wfrm_pkg::PTR_W'(wfrm_pkg::MAX_WINDOW - 1);
                    else
                        rd_ptr_reg <= rd_ptr_reg - 1'b1;
                end
                wfrm_pkg::OP_DRAIN:
                begin
                    sum_reg  <= sum_reg + wfrm_pkg::SUM_W'(rd_q_reg);
                    pend_reg <= 1'b0;
                end
                wfrm_pkg::OP_DIV_SUM:
                begin
                    dvd_reg  <= sum_reg;
                    dvsr_reg <= wfrm_pkg::AVG_W'(fill_reg);
                    rem_reg  <= '0;
                    dcnt_reg <= wfrm_pkg::DCNT_W'(wfrm_pkg::SUM_W);
                end
                wfrm_pkg::OP_DIV_STEP:
                begin
                    rem_reg  <= rem_ge ? rem_diff[wfrm_pkg::AVG_W-1:0]
                                       : rem_sh[wfrm_pkg::AVG_W-1:0];
                    dvd_reg  <= {dvd_reg[wfrm_pkg::SUM_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                wfrm_pkg::OP_SET_AVG:
                begin
                    cur_avg_reg <= dvd_reg[wfrm_pkg::AVG_W-1:0];
                    dvd_reg     <= wfrm_pkg::SUM_W'(wfrm_pkg::FPS_NUM);
                    dvsr_reg    <= dvd_reg[wfrm_pkg::AVG_W-1:0];
                    rem_reg     <= '0;
                    dcnt_reg    <= wfrm_pkg::DCNT_W'(wfrm_pkg::SUM_W);
                end
                wfrm_pkg::OP_SET_FPS:
                begin
                    cur_fps_reg <= (cur_avg_reg == '0) ? '0 : dvd_reg[wfrm_pkg::FPS_W-1:0];
                end
                wfrm_pkg::OP_SHOW:
                begin
                    if (!seen_show_reg || elapsed >= wfrm_pkg::TS_W'(show_thr))
                    begin
                        held_avg_reg  <= cur_avg_reg;
                        held_fps_reg  <= cur_fps_reg;
                        prev_show_reg <= now_reg;
                        seen_show_reg <= 1'b1;
                    end
                end
                wfrm_pkg::OP_EMIT:
                begin
                    if (!out_busy)
                    begin
                        m_tdata_reg  <= {7'b0, held_fps_reg, held_avg_reg,
                                         cur_fps_reg, cur_avg_reg, seen_show_reg};
                    end
                end
                wfrm_pkg::OP_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the windowed frame rate meter with its own reading predictor.
module tb_top;

    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 90;
    localparam int WANT_DEPTH = 1024;
    localparam int OUT_USED = 1 + 2 * wfrm_pkg::AVG_W + 2 * wfrm_pkg::FPS_W;
    localparam logic [wfrm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = wfrm_pkg::CFG_IDX_W'(2);
    localparam logic [wfrm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = wfrm_pkg::CFG_IDX_W'(3);

    typedef struct packed {
        logic                       measured;
        logic [wfrm_pkg::AVG_W-1:0] avg_us;
        logic [wfrm_pkg::FPS_W-1:0] fps;
        logic [wfrm_pkg::AVG_W-1:0] shown_us;
        logic [wfrm_pkg::FPS_W-1:0] shown_fps;
    } reading_t;

    typedef struct {
        logic                           is_write;
        logic [wfrm_pkg::CFG_IDX_W-1:0] idx;
        logic [wfrm_pkg::CFG_W-1:0]     val;
        logic [wfrm_pkg::TS_W-1:0]      ts;
        logic                           typed;
        reading_t                       want;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [wfrm_pkg::TS_W-1:0]      s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [wfrm_pkg::OUT_W-1:0]     m_tdata;
    logic                           cfg_we;
    logic [wfrm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wfrm_pkg::CFG_W-1:0]     cfg_data;

    // Predictor state.
    logic [wfrm_pkg::AVG_W-1:0]  ring_mem [wfrm_pkg::MAX_WINDOW];
    logic [wfrm_pkg::PTR_W-1:0]  slot;
    logic [wfrm_pkg::FILL_W-1:0] fill;
    logic [wfrm_pkg::TS_W-1:0]   last_frame_ts;
    logic [wfrm_pkg::TS_W-1:0]   last_show_ts;
    logic                        got_frame;
    logic                        got_show;
    logic [wfrm_pkg::AVG_W-1:0]  avg_now;
    logic [wfrm_pkg::AVG_W-1:0]  avg_held;
    logic [wfrm_pkg::FPS_W-1:0]  fps_now;
    logic [wfrm_pkg::FPS_W-1:0]  fps_held;
    logic [wfrm_pkg::WIN_W-1:0]  window_len;
    logic [wfrm_pkg::SHOW_W-1:0] show_ms;

    reading_t                  want_fifo [WANT_DEPTH];
    int                        want_wr;
    int                        want_rd;
    stim_row_t                 dir_rows[18];
    logic [wfrm_pkg::TS_W-1:0] sent_ts;
    int                        burst_left;
    int                        errors;
    int                        frames_sent;
    int                        readings_seen;
    int                        reg_writes;
    int                        latches;
    int                        zero_fps;
    longint                    cycles;

    windowed_frame_rate_meter_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int window_in_use();
        int w;
        w = window_len;
        if (w > wfrm_pkg::MAX_WINDOW)
            w = wfrm_pkg::MAX_WINDOW;
        if (w < 1)
            w = 1;
        return w;
    endfunction

    function automatic void apply_write(input logic [wfrm_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [wfrm_pkg::CFG_W-1:0] val);
        logic [wfrm_pkg::WIN_W-1:0]  w;
        logic [wfrm_pkg::SHOW_W-1:0] s;
        if (idx == wfrm_pkg::REG_WINDOW_LEN)
        begin
            w = val[wfrm_pkg::WIN_W-1:0];
            if (w < 1)
                w = 1;
            if (w > wfrm_pkg::WIN_MAX_REG)
                w = wfrm_pkg::WIN_MAX_REG;
            window_len = w;
            if (int'(fill) > window_in_use())
                fill = wfrm_pkg::FILL_W'(window_in_use());
        end
        else if (idx == wfrm_pkg::REG_DISPLAY_MS)
        begin
            s = val[wfrm_pkg::SHOW_W-1:0];
            if (s < wfrm_pkg::SHOW_MIN_MS)
                s = wfrm_pkg::SHOW_MIN_MS;
            if (s > wfrm_pkg::SHOW_MAX_MS)
                s = wfrm_pkg::SHOW_MAX_MS;
            show_ms = s;
        end
    endfunction

    function automatic reading_t next_reading(input logic [wfrm_pkg::TS_W-1:0] ts);
        logic [wfrm_pkg::TS_W-1:0]  delta;
        logic [wfrm_pkg::TS_W-1:0]  elapsed;
        logic [wfrm_pkg::SUM_W-1:0] total;
        logic [wfrm_pkg::PTR_W-1:0] at;
        int                         win;
        reading_t                   r;
        if (!got_frame)
        begin
            last_frame_ts = ts;
            last_show_ts  = ts;
            got_frame     = 1'b1;
        end
        else
        begin
            delta          = ts - last_frame_ts;
            last_frame_ts  = ts;
            ring_mem[slot] = delta;
            slot           = slot + 1'b1;
            win            = window_in_use();
            if (int'(fill) + 1 > win)
                fill = wfrm_pkg::FILL_W'(win);
            else
                fill = fill + 1'b1;
            total = '0;
            for (int k = 0; k < int'(fill); k++)
            begin
                at    = slot - wfrm_pkg::PTR_W'(k + 1);
                total = total + wfrm_pkg::SUM_W'(ring_mem[at]);
            end
            avg_now = wfrm_pkg::AVG_W'(total / fill);
            fps_now = (avg_now != 0) ?
                      wfrm_pkg::FPS_W'(32'(wfrm_pkg::FPS_NUM) / avg_now) : '0;
            elapsed = ts - last_show_ts;
            if (!got_show || elapsed >= 32'(show_ms) * 32'(wfrm_pkg::US_PER_MS))
            begin
                avg_held     = avg_now;
                fps_held     = fps_now;
                last_show_ts = ts;
                got_show     = 1'b1;
                latches++;
            end
            if (fps_now == 0)
                zero_fps++;
        end
        r = '{got_show, avg_now, fps_now, avg_held, fps_held};
        return r;
    endfunction

    function automatic logic [wfrm_pkg::TS_W-1:0] frame_gap(input int unsigned base);
        int unsigned               pick;
        logic [wfrm_pkg::TS_W-1:0] due;
        pick = $urandom_range(0, 99);
        due  = 32'(show_ms) * 32'(wfrm_pkg::US_PER_MS) - (last_frame_ts - last_show_ts);
        if (pick < 70)
            return base - base / 16 + $urandom_range(0, base / 8);
        else if (pick < 78)
            return $urandom_range(0, 50);
        else if (pick < 86)
            return $urandom_range(100_000, 6_000_000);
        else if (pick < 92)
            return $urandom;
        else
            return due - $urandom_range(0, 1);
    endfunction

    function automatic stim_row_t fr(input logic [wfrm_pkg::TS_W-1:0] ts);
        stim_row_t r;
        r = '{1'b0, '0, '0, ts, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t fx(input logic [wfrm_pkg::TS_W-1:0] ts,
                                     input reading_t want);
        stim_row_t r;
        r = '{1'b0, '0, '0, ts, 1'b1, want};
        return r;
    endfunction

    function automatic stim_row_t wr(input logic [wfrm_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [wfrm_pkg::CFG_W-1:0] val);
        stim_row_t r;
        r = '{1'b1, idx, val, '0, 1'b0, '0};
        return r;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, seen);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (want_wr != want_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wfrm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wfrm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        apply_write(idx, val);
        reg_writes++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic send_frame(input logic [wfrm_pkg::TS_W-1:0] ts, input logic typed,
                              input reading_t want);
        reading_t p;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = ts;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        p = next_reading(ts);
        want_fifo[want_wr % WANT_DEPTH] = typed ? want : p;
        want_wr++;
        sent_ts = ts;
        frames_sent++;
        burst_left--;
    endtask

    // Receiver backpressure: modes of always ready, coin flip and mostly stalled.
    initial
    begin
        int mode;
        int left;
        m_tready = 1'b0;
        mode     = 0;
        left     = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                0:       m_tready = 1'b1;
                1:       m_tready = $urandom_range(0, 1);
                default: m_tready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        reading_t seen;
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            readings_seen++;
            seen = '{m_tdata[0], m_tdata[32:1], m_tdata[56:33], m_tdata[88:57],
                     m_tdata[112:89]};
            if (want_wr == want_rd)
            begin
                errors++;
                $display("%0t: unexpected beat, data %h", $time, m_tdata);
            end
            else
            begin
                want = want_fifo[want_rd % WANT_DEPTH];
                want_rd++;
                check_field("measured", 32'(want.measured), 32'(seen.measured));
                check_field("avg_frame_us", want.avg_us, seen.avg_us);
                check_field("fps_x16", 32'(want.fps), 32'(seen.fps));
                check_field("shown_frame_us", want.shown_us, seen.shown_us);
                check_field("shown_fps_x16", 32'(want.shown_fps), 32'(seen.shown_fps));
                check_field("zero fill", 32'd0,
                            32'(m_tdata[wfrm_pkg::OUT_W-1:OUT_USED]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d readings outstanding", cycles,
                     want_wr - want_rd);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int unsigned                base;
        logic [wfrm_pkg::CFG_W-1:0] win_raw;
        logic [wfrm_pkg::CFG_W-1:0] show_raw;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = wfrm_pkg::REG_WINDOW_LEN;
        cfg_data  = '0;
        errors        = 0;
        frames_sent   = 0;
        readings_seen = 0;
        reg_writes    = 0;
        latches       = 0;
        zero_fps      = 0;
        cycles        = 0;
        burst_left    = 0;
        sent_ts       = '0;
        want_wr       = 0;
        want_rd       = 0;

        slot          = '0;
        fill          = '0;
        last_frame_ts = '0;
        last_show_ts  = '0;
        got_frame     = 1'b0;
        got_show      = 1'b0;
        avg_now       = '0;
        avg_held      = '0;
        fps_now       = '0;
        fps_held      = '0;
        window_len    = wfrm_pkg::WIN_RESET;
        show_ms       = wfrm_pkg::SHOW_RESET;

        dir_rows = '{
            fx(32'hFFFF_FFF0, '{1'b0, 32'd0, 24'd0, 32'd0, 24'd0}),
            fx(32'h0000_0010, '{1'b1, 32'd32, 24'd500000, 32'd32, 24'd500000}),
            fx(32'h0000_0010, '{1'b1, 32'd16, 24'd1000000, 32'd32, 24'd500000}),
            fr(32'h0001_3890),
            fr(32'h0002_710F),
            fr(32'h0002_7110),
            wr(wfrm_pkg::REG_WINDOW_LEN, 13'd0),
            fr(32'h0002_7110),
            fr(32'h0002_7111),
            wr(wfrm_pkg::REG_DISPLAY_MS, 13'd0),
            fr(32'hFFFF_FFFF),
            fr(32'h0000_0000),
            wr(wfrm_pkg::REG_WINDOW_LEN, 13'h1FFF),
            wr(wfrm_pkg::REG_DISPLAY_MS, 13'h1FFF),
            wr(REG_SPARE_B, 13'd0),
            fr(32'h8000_0000),
            fr(32'h804C_4B3F),
            fr(32'h804C_4B40)
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_write)
            begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                pace();
                send_frame(dir_rows[i].ts, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:       win_raw = 13'd1;
                1:       win_raw = 13'h3FF;
                2:       win_raw = wfrm_pkg::CFG_W'($urandom_range(2, 24));
                3:       win_raw = 13'd0;
                4:       win_raw = wfrm_pkg::CFG_W'($urandom_range(0, 8191));
                default: win_raw = wfrm_pkg::CFG_W'(wfrm_pkg::WIN_MAX_REG);
            endcase
            case ($urandom_range(0, 5))
                0:       show_raw = 13'd0;
                1:       show_raw = wfrm_pkg::CFG_W'(wfrm_pkg::SHOW_MIN_MS);
                2:       show_raw = wfrm_pkg::CFG_W'(wfrm_pkg::SHOW_MAX_MS);
                3:       show_raw = 13'h1FFF;
                4:       show_raw = wfrm_pkg::CFG_W'($urandom_range(16, 300));
                default: show_raw = wfrm_pkg::CFG_W'($urandom_range(0, 8191));
            endcase
            write_reg(wfrm_pkg::REG_WINDOW_LEN, win_raw);
            write_reg(wfrm_pkg::REG_DISPLAY_MS, show_raw);
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_SPARE_A, wfrm_pkg::CFG_W'($urandom_range(0, 8191)));
            base = $urandom_range(1000, 60000);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pace();
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                send_frame(sent_ts + frame_gap(base), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (want_wr != want_rd)
        begin
            errors++;
            $display("%0t: %0d readings never arrived", $time, want_wr - want_rd);
        end

        $display("Run covered %0d frame markers, %0d readings and %0d register writes.",
                 frames_sent, readings_seen, reg_writes);
        $display("Display copies latched %0d times; %0d readings had a zero frame rate.",
                 latches, zero_fps);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
sv/wfrm_pkg.sv
sv/windowed_frame_rate_meter_unit.sv
tb/tb_top.sv
